### rtl/assert_macros.svh
// Assertion macros for the RTL files of the CIDR calculator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/ipcalc_pkg.sv
// Types, codes, the address rule table and the classifier of the CIDR calculator.
package ipcalc_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] address;
        logic [5:0]  prefix_length;
        logic [31:0] subnet_mask;
        logic [31:0] network_address;
        logic        network_valid;
        logic [31:0] broadcast_address;
        logic        broadcast_valid;
        logic [31:0] first_host;
        logic [31:0] last_host;
        logic [31:0] host_count;
        logic [4:0]  address_kind;
    } out_t;

    typedef enum logic [2:0] {
        LX_START = 3'd0,
        LX_OCT   = 3'd1,
        LX_DOT   = 3'd2,
        LX_SLASH = 3'd3,
        LX_MASK  = 3'd4,
        LX_ERR   = 3'd5
    } lex_t;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SYNTAX      = 3'd1;
    localparam logic [2:0] ST_OCTET_COUNT = 3'd2;
    localparam logic [2:0] ST_OCTET_RANGE = 3'd3;
    localparam logic [2:0] ST_PREFIX      = 3'd4;

    localparam logic [4:0] KIND_PUBLIC_A = 5'd16;
    localparam logic [4:0] KIND_PUBLIC_B = 5'd17;
    localparam logic [4:0] KIND_PUBLIC_C = 5'd18;

    localparam logic [7:0] CLASS_A_TOP = 8'd127;
    localparam logic [7:0] CLASS_B_TOP = 8'd191;

    localparam int NUM_RULES = 16;

    localparam logic [31:0] RULE_ADDR [NUM_RULES] = '{
        32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'h64400000,
        32'h7F000000, 32'hA9FE0000, 32'hC0000000, 32'hC0000200,
        32'hC6120000, 32'hC6336400, 32'hCB007100, 32'h0A000000,
        32'hAC100000, 32'hC0A80000, 32'hE0000000, 32'hF0000000
    };

    localparam logic [31:0] RULE_MASK [NUM_RULES] = '{
        32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFF000000, 32'hFFC00000,
        32'hFF000000, 32'hFFFF0000, 32'hFFFFFF00, 32'hFFFFFF00,
        32'hFFFE0000, 32'hFFFFFF00, 32'hFFFFFF00, 32'hFF000000,
        32'hFFF00000, 32'hFFFF0000, 32'hF0000000, 32'hF0000000
    };

    // Only the "this network" rule is skipped for a zero prefix.
    localparam logic [NUM_RULES-1:0] RULE_NEEDS_PREFIX = 16'b0000_0000_0000_0100;

    // First matching rule wins; otherwise public class by the first octet.
    function automatic logic [4:0] classify(input logic [31:0] addr,
                                            input logic [5:0]  prefix);
        logic [4:0] kind;
        logic       hit;
        logic [7:0] top;
        hit  = 1'b0;
        kind = KIND_PUBLIC_C;
        top  = addr[31:24];
        for (int i = 0; i < NUM_RULES; i++) begin
            if (!hit && ((addr & RULE_MASK[i]) == RULE_ADDR[i])
                    && !(RULE_NEEDS_PREFIX[i] && (prefix == 6'd0))) begin
                hit  = 1'b1;
                kind = 5'(i);
            end
        end
        if (!hit) begin
            if (top <= CLASS_A_TOP) begin
                kind = KIND_PUBLIC_A;
            end else if (top <= CLASS_B_TOP) begin
                kind = KIND_PUBLIC_B;
            end else begin
                kind = KIND_PUBLIC_C;
            end
        end
        return kind;
    endfunction

endpackage

### rtl/ipv4_cidr_parse_and_subnet_calc.sv
// Top level of the IPv4 CIDR text parser and subnet calculator.
// This block reads CIDR text such as "192.168.1.7/24" one character per item
// and, on an item with end_of_text set, returns one result item with the
// status, the parsed address and prefix, the mask, network and broadcast
// addresses, the host range, the usable host count and the address kind. Any
// error status zeroes every other field. The block takes one item per cycle
// while the output register does not stall it: an accepted item sits in an
// input register, the lexer and the subnet arithmetic act on it there, and an
// end item's result is written to the output register as the end item leaves
// the input register. The only stall comes from the output register: an end
// item waits in the input register while an earlier result has not been taken,
// and the input side then holds off further items. After each end item the
// lexer returns to its start state, ready for the next text.
module ipv4_cidr_parse_and_subnet_calc (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ipcalc_pkg::in_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ipcalc_pkg::out_t  m_data
);
    import ipcalc_pkg::*;

    `include "assert_macros.svh"

    // Input register.
    logic in_valid_reg, in_valid_next;
    in_t  in_data_reg;

    // Lexer state.
    lex_t        lex_state_reg, lex_state_next;
    logic [2:0]  octets_seen_reg, octets_seen_next;
    logic [8:0]  number_acc_reg, number_acc_next;
    logic [31:0] address_shift_reg, address_shift_next;
    logic        range_error_reg, range_error_next;

    // Output register.
    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;

    logic        out_free;
    logic        in_advance;
    logic        result_load;
    logic        is_digit;
    logic [3:0]  digit_value;
    logic [12:0] acc_times_ten;
    logic [8:0]  acc_digit;
    logic [2:0]  octets_inc;
    logic [5:0]  prefix;
    logic [31:0] mask;
    logic [31:0] net;
    logic [31:0] bcast;
    logic [2:0]  status;

    // An end item can move on only when the output register is free or
    // being emptied this cycle; a plain character always moves on.
    assign out_free    = !m_valid_reg || m_ready;
    assign in_advance  = in_valid_reg && (!in_data_reg.end_of_text || out_free);
    assign result_load = in_advance && in_data_reg.end_of_text;
    assign s_ready     = !in_valid_reg || in_advance;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (in_advance) begin
            in_valid_next = 1'b0;
        end
    end

    // Decimal accumulation saturates at 256, so overlong runs fail the
    // octet or prefix range check.
    assign is_digit      = (in_data_reg.character >= 8'h30) && (in_data_reg.character <= 8'h39);
    assign digit_value   = 4'(in_data_reg.character - 8'h30);
    assign acc_times_ten = {1'b0, number_acc_reg, 3'b000} + {3'b000, number_acc_reg, 1'b0}
                           + {9'd0, digit_value};
    assign acc_digit     = (acc_times_ten > 13'd256) ? 9'd256 : acc_times_ten[8:0];
    assign octets_inc    = (octets_seen_reg == 3'd7) ? 3'd7 : octets_seen_reg + 3'd1;

    always_comb begin
        lex_state_next     = lex_state_reg;
        octets_seen_next   = octets_seen_reg;
        number_acc_next    = number_acc_reg;
        address_shift_next = address_shift_reg;
        range_error_next   = range_error_reg;
        if (in_advance) begin
            if (in_data_reg.end_of_text) begin
                lex_state_next     = LX_START;
                octets_seen_next   = 3'd0;
                number_acc_next    = 9'd0;
                address_shift_next = 32'd0;
                range_error_next   = 1'b0;
            end else if (is_digit) begin
                unique case (lex_state_reg)
                    LX_START, LX_OCT, LX_DOT: begin
                        number_acc_next = acc_digit;
                        lex_state_next  = LX_OCT;
                    end
                    LX_SLASH, LX_MASK: begin
                        number_acc_next = acc_digit;
                        lex_state_next  = LX_MASK;
                    end
                    default: begin
                        lex_state_next = LX_ERR;
                    end
                endcase
            end else if (lex_state_reg == LX_OCT
                         && (in_data_reg.character == 8'h2E
                             || in_data_reg.character == 8'h2F)) begin
                // A dot or a slash closes the current octet.
                if (number_acc_reg[8]) begin
                    range_error_next = 1'b1;
                end
                address_shift_next = {address_shift_reg[23:0], number_acc_reg[7:0]};
                octets_seen_next   = octets_inc;
                number_acc_next    = 9'd0;
                lex_state_next     = (in_data_reg.character == 8'h2E) ? LX_DOT : LX_SLASH;
            end else begin
                lex_state_next = LX_ERR;
            end
        end
    end

    // Result arithmetic on the state left by the text.
    assign prefix = number_acc_reg[5:0];
    assign mask   = ~(32'hFFFFFFFF >> prefix);
    assign net    = address_shift_reg & mask;
    assign bcast  = net | ~mask;

    always_comb begin
        priority if (lex_state_reg != LX_MASK) begin
            status = ST_SYNTAX;
        end else if (octets_seen_reg != 3'd4) begin
            status = ST_OCTET_COUNT;
        end else if (range_error_reg) begin
            status = ST_OCTET_RANGE;
        end else if (number_acc_reg > 9'd32) begin
            status = ST_PREFIX;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        m_data_next        = '0;
        m_data_next.status = status;
        if (status == ST_OK) begin
            m_data_next.address           = address_shift_reg;
            m_data_next.prefix_length     = prefix;
            m_data_next.subnet_mask       = mask;
            m_data_next.network_valid     = (prefix != 6'd31);
            m_data_next.network_address   = (prefix != 6'd31) ? net : 32'd0;
            m_data_next.broadcast_valid   = (prefix <= 6'd30);
            m_data_next.broadcast_address = (prefix <= 6'd30) ? bcast : 32'd0;
            m_data_next.address_kind      = classify(address_shift_reg, prefix);
            if (prefix == 6'd32) begin
                m_data_next.first_host = address_shift_reg;
                m_data_next.last_host  = address_shift_reg;
                m_data_next.host_count = 32'd1;
            end else if (prefix == 6'd31) begin
                m_data_next.first_host = address_shift_reg;
                m_data_next.last_host  = address_shift_reg + 32'd1;
                m_data_next.host_count = 32'd2;
            end else begin
                // The inverted mask is the block size minus one.
                m_data_next.first_host = net + 32'd1;
                m_data_next.last_host  = bcast - 32'd1;
                m_data_next.host_count = ~mask - 32'd1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (result_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            lex_state_reg     <= LX_START;
            octets_seen_reg   <= 3'd0;
            number_acc_reg    <= 9'd0;
            address_shift_reg <= 32'd0;
            range_error_reg   <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            in_valid_reg      <= in_valid_next;
            lex_state_reg     <= lex_state_next;
            octets_seen_reg   <= octets_seen_next;
            number_acc_reg    <= number_acc_next;
            address_shift_reg <= address_shift_next;
            range_error_reg   <= range_error_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (result_load) begin
            m_data_reg <= m_data_next;
        end
    end

    `ASSERT_NEXT(a_end_clears_lexer, result_load,
        lex_state_reg == LX_START && octets_seen_reg == 3'd0 && number_acc_reg == 9'd0,
        "lexer not back at start after end item")

    `ASSERT_IMPLY(a_error_zeroes_fields, m_valid_reg && m_data_reg.status != ST_OK,
        m_data_reg.address == 32'd0 && m_data_reg.host_count == 32'd0,
        "error result carries nonzero fields")

    `ASSERT_IMPLY(a_network_valid_rule, m_valid_reg && m_data_reg.status == ST_OK,
        m_data_reg.network_valid == (m_data_reg.prefix_length != 6'd31),
        "network_valid disagrees with prefix")

    `ASSERT_IMPLY(a_broadcast_needs_network, m_valid_reg && m_data_reg.broadcast_valid,
        m_data_reg.network_valid && m_data_reg.prefix_length <= 6'd30,
        "broadcast valid without valid network")

endmodule
